// ===== rtl/core/time_window_price_averager_top_assert.svh =====
// Assertion macros for the time window price averager.
`ifndef TIME_WINDOW_PRICE_AVERAGER_TOP_ASSERT_SVH
`define TIME_WINDOW_PRICE_AVERAGER_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define TWPA_CHK_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define TWPA_CHK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/twpa_pkg.sv =====
// ----------------------------------------------------------------------------
// twpa_pkg
// Shared types and field widths of the time window price averager.
// ----------------------------------------------------------------------------
`default_nettype none

package twpa_pkg;

    localparam int TIME_W  = 40;
    localparam int PRICE_W = 32;
    localparam int VOL_W   = 32;
    localparam int TURN_W  = 48;
    localparam int SPAN_W  = 20;
    localparam int WGT_W   = 16;

    // One stored tick.
    typedef struct packed {
        logic [TURN_W-1:0]  turnover;
        logic [VOL_W-1:0]   volume;
        logic [PRICE_W-1:0] price;
        logic [TIME_W-1:0]  tick_time;
    } t_tick;

    // Shift control shared by every cell of the chain.
    typedef struct packed {
        logic rot;  // rotate toward cell 0 (walk)
        logic ins;  // shift toward the far end, new tick enters cell 0
    } t_cell_ctrl;

endpackage

`default_nettype wire

// ===== rtl/core/twpa_cell.sv =====
// ----------------------------------------------------------------------------
// twpa_cell
// One history cell: holds a stored tick and passes it to a neighbor.
// ----------------------------------------------------------------------------
`default_nettype none

module twpa_cell (
    input  wire                  i_clk,
    input  twpa_pkg::t_cell_ctrl i_ctrl,
    input  twpa_pkg::t_tick      i_rot,
    input  twpa_pkg::t_tick      i_ins,
    output twpa_pkg::t_tick      o_tick
);
    import twpa_pkg::*;

    t_tick r_tick;

    // Insertion wins over rotation; the two never overlap in practice.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.ins) begin
            r_tick <= i_ins;
        end else if (i_ctrl.rot) begin
            r_tick <= i_rot;
        end
    end

    assign o_tick = r_tick;

endmodule

`default_nettype wire

// ===== rtl/core/twpa_div.sv =====
// ----------------------------------------------------------------------------
// twpa_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module twpa_div #(
    parameter int DW = 55,
    parameter int VW = 39
) (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_start,
    input  wire  [DW-1:0] i_dividend,
    input  wire  [VW-1:0] i_divisor,
    output logic          o_busy,
    output logic [DW-1:0] o_quot
);
    localparam int CNTW = $clog2(DW + 1);

    logic [CNTW-1:0] r_cnt;
    logic [DW-1:0]   r_quot;
    logic [VW-1:0]   r_rem;
    logic [VW-1:0]   r_div;
    logic [VW:0]     w_sh;
    logic            w_ge;

    assign w_sh = {r_rem, r_quot[DW-1]};
    assign w_ge = (w_sh >= {1'b0, r_div});

    // Step counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CNTW'(DW);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    // Partial remainder and quotient share the shift register.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_dividend;
            r_rem  <= '0;
            r_div  <= i_divisor;
        end else if (r_cnt != '0) begin
            r_quot <= {r_quot[DW-2:0], w_ge};
            if (w_ge) begin
                r_rem <= VW'(w_sh - {1'b0, r_div});
            end else begin
                r_rem <= w_sh[VW-1:0];
            end
        end
    end

    assign o_busy = (r_cnt != '0);
    assign o_quot = r_quot;

endmodule

`default_nettype wire

// ===== rtl/core/time_window_price_averager_top.sv =====
// Time window price averager. Each tick transfer yields one result of plain,
// linearly weighted and volume weighted mean price over the current tick and
// the stored ticks still inside the window. For each item the history chain
// is rotated once through all HISTORY_DEPTH cells, then three bit-serial
// dividers run side by side. One item is worked on at a time; the next tick
// is taken while a result still waits on the master side. History entries
// not yet written are never read.
`default_nettype none

module time_window_price_averager_top #(
    parameter int HISTORY_DEPTH = 64
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // Configuration write channel.
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [1:0]  i_cfg_index,
    input  wire  [19:0] i_cfg_data,
    // Tick input.
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: tick_time[39:0], price[71:40], volume[103:72], turnover[151:104]
    input  wire  [151:0] s_axis_tdata,
    // Result output.
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // tdata: mean_price, weighted_price, vwap, vwap_valid, window_count, zero pad
    output logic [((97 + $clog2(HISTORY_DEPTH + 2) + 7) / 8) * 8 - 1:0] m_axis_tdata
);
    import twpa_pkg::*;

    `include "time_window_price_averager_top_assert.svh"

    localparam int D    = HISTORY_DEPTH;
    localparam int KW   = $clog2(D);
    localparam int FW   = $clog2(D + 1);
    localparam int CW   = $clog2(D + 2);
    localparam int PSW  = PRICE_W + CW;
    localparam int WSW  = PRICE_W + WGT_W + CW;
    localparam int WTW  = WGT_W + CW;
    localparam int VSW  = VOL_W + CW;
    localparam int TSW  = TURN_W + CW;
    localparam int OUTW = ((97 + CW + 7) / 8) * 8;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_WALK  = 3'd1;
    localparam logic [2:0] ST_FLUSH = 3'd2;
    localparam logic [2:0] ST_START = 3'd3;
    localparam logic [2:0] ST_DIV   = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    localparam logic [1:0] REG_SPAN   = 2'd0;
    localparam logic [1:0] REG_WEIGHT = 2'd1;

    logic [2:0]          r_state;
    logic [SPAN_W-1:0]   r_span;
    logic [WGT_W-1:0]    r_wstart;
    logic [KW-1:0]       r_k;
    logic [FW-1:0]       r_fill;
    logic                r_stop;
    t_tick               r_cur;
    logic [WGT_W-1:0]    r_weight;
    logic [PSW-1:0]      r_psum;
    logic [WSW-1:0]      r_wsum;
    logic [WTW-1:0]      r_wtsum;
    logic [VSW-1:0]      r_vsum;
    logic [TSW-1:0]      r_tsum;
    logic [CW-1:0]       r_count;
    logic [PRICE_W+WGT_W-1:0] r_prod;
    logic                r_out_v;
    logic [OUTW-1:0]     r_out;

    t_tick               w_tick [D];
    t_tick               w_head;
    t_cell_ctrl          w_ctrl;
    logic [WGT_W-1:0]    w_wnext;
    logic                w_in_win;
    logic                w_active;
    logic [PRICE_W-1:0]  w_mul_a;
    logic [WGT_W-1:0]    w_mul_b;
    logic [PRICE_W+WGT_W-1:0] w_prod;
    logic                w_in_acc;
    logic                w_load;
    logic                w_div_start;
    logic                w_busy_m, w_busy_w, w_busy_v;
    logic [PSW-1:0]      w_q_m;
    logic [WSW-1:0]      w_q_w;
    logic [TSW-1:0]      w_q_v;
    logic [PRICE_W-1:0]  w_mean, w_wavg, w_vwap;
    logic                w_vvalid;

    assign w_in_acc    = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_load      = (r_state == ST_DONE) && (!r_out_v || m_axis_tready);
    assign w_div_start = (r_state == ST_START);

    // History chain: rotates during the walk, shifts in the new tick at the end.
    assign w_ctrl.rot = (r_state == ST_WALK);
    assign w_ctrl.ins = w_load;
    assign w_head     = w_tick[0];

    for (genvar gi = 0; gi < D; gi++) begin : g_cell
        localparam int NXT = (gi + 1) % D;
        t_tick w_ins;
        if (gi == 0) begin : g_first
            assign w_ins = r_cur;
        end else begin : g_rest
            assign w_ins = w_tick[gi-1];
        end
        twpa_cell u_cell (
            .i_clk  (i_clk),
            .i_ctrl (w_ctrl),
            .i_rot  (w_tick[NXT]),
            .i_ins  (w_ins),
            .o_tick (w_tick[gi])
        );
    end

    // Window test and weight step for the tick at the head of the chain.
    assign w_wnext  = (r_weight == '0) ? '0 : r_weight - 1'b1;
    assign w_in_win = ({1'b0, w_head.tick_time} + (TIME_W+1)'(r_span))
                      > {1'b0, r_cur.tick_time};
    assign w_active = (r_state == ST_WALK) && !r_stop && (FW'(r_k) < r_fill) && w_in_win;

    // One shared multiplier: current tick on transfer, stored ticks on the walk.
    assign w_mul_a = (r_state == ST_IDLE) ? s_axis_tdata[71:40] : w_head.price;
    assign w_mul_b = (r_state == ST_IDLE) ? r_wstart : w_wnext;
    assign w_prod  = w_mul_a * w_mul_b;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_span   <= SPAN_W'(120);
            r_wstart <= WGT_W'(120);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_SPAN:   r_span   <= i_cfg_data;
                REG_WEIGHT: r_wstart <= i_cfg_data[WGT_W-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_fill  <= '0;
            r_k     <= '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (w_in_acc) begin
                        r_state <= ST_WALK;
                        r_k     <= '0;
                    end
                end
                ST_WALK: begin
                    r_k <= r_k + 1'b1;
                    if (r_k == KW'(D - 1)) begin
                        r_state <= ST_FLUSH;
                    end
                end
                ST_FLUSH: r_state <= ST_START;
                ST_START: r_state <= ST_DIV;
                ST_DIV: begin
                    if (!w_busy_m && !w_busy_w && !w_busy_v) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (w_load) begin
                        r_state <= ST_IDLE;
                        if (r_fill != FW'(D)) begin
                            r_fill <= r_fill + 1'b1;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Accumulators.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE) begin
            r_stop   <= 1'b0;
            if (w_in_acc) begin
                r_cur    <= s_axis_tdata;
                r_weight <= r_wstart;
                r_psum   <= PSW'(s_axis_tdata[71:40]);
                r_wsum   <= '0;
                r_prod   <= w_prod;
                r_wtsum  <= WTW'(r_wstart);
                r_vsum   <= VSW'(s_axis_tdata[103:72]);
                r_tsum   <= TSW'(s_axis_tdata[151:104]);
                r_count  <= CW'(1);
            end
        end else if (r_state == ST_WALK) begin
            r_wsum <= r_wsum + WSW'(r_prod);
            if (w_active) begin
                r_weight <= w_wnext;
                r_prod   <= w_prod;
                r_psum   <= r_psum + PSW'(w_head.price);
                r_wtsum  <= r_wtsum + WTW'(w_wnext);
                r_vsum   <= r_vsum + VSW'(w_head.volume);
                r_tsum   <= r_tsum + TSW'(w_head.turnover);
                r_count  <= r_count + 1'b1;
            end else begin
                r_prod <= '0;
                r_stop <= 1'b1;
            end
        end else if (r_state == ST_FLUSH) begin
            r_wsum <= r_wsum + WSW'(r_prod);
        end
    end

    // Three dividers run in parallel.
    twpa_div #(.DW(PSW), .VW(CW)) u_div_mean (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_start (w_div_start),
        .i_dividend (r_psum), .i_divisor (r_count),
        .o_busy (w_busy_m), .o_quot (w_q_m)
    );
    twpa_div #(.DW(WSW), .VW(WTW)) u_div_wgt (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_start (w_div_start),
        .i_dividend (r_wsum), .i_divisor (r_wtsum),
        .o_busy (w_busy_w), .o_quot (w_q_w)
    );
    twpa_div #(.DW(TSW), .VW(VSW)) u_div_vwap (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_start (w_div_start),
        .i_dividend (r_tsum), .i_divisor (r_vsum),
        .o_busy (w_busy_v), .o_quot (w_q_v)
    );

    // Result fields, with the zero-divisor cases forced.
    assign w_mean   = w_q_m[PRICE_W-1:0];
    assign w_wavg   = (r_wtsum == '0) ? '0 : w_q_w[PRICE_W-1:0];
    assign w_vvalid = (r_vsum != '0);
    assign w_vwap   = !w_vvalid ? '0 :
                      (|w_q_v[TSW-1:PRICE_W]) ? '1 : w_q_v[PRICE_W-1:0];

    // Output register: holds a result until its transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_load) begin
            r_out_v <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out <= OUTW'({r_count, w_vvalid, w_vwap, w_wavg, w_mean});
        end
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = r_out;

    `TWPA_CHK_NOW(a_fill_bound, 1'b1, r_fill <= FW'(D), "fill level above depth")
    `TWPA_CHK_NEXT(a_acc_walk, w_in_acc, r_state == ST_WALK, "tick transfer did not start walk")
    `TWPA_CHK_NOW(a_count_bound, w_load, CW'(r_count) <= CW'(r_fill) + CW'(1),
        "window count exceeds stored ticks")

endmodule

`default_nettype wire
